### hw/rtl/fcrc_pkg.sv
// Package: shared types, header codes and the CRC-16 byte update for the frame receiver.
package fcrc_pkg;

	localparam logic [7:0] HDR_FIRST    = 8'h3B;
	localparam logic [7:0] HDR_SECOND   = 8'h01;
	localparam logic [7:0] MIN_LAST_IDX = 8'd3;
	localparam logic [7:0] SHORT_LEN    = 8'd4;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_REQ  = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [7:0] byte_index;
		logic       last;
		logic       crc_ok;
	} res_t;

	// Reflected 0x1021 update, one byte, table-free form.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  d;
		logic [15:0] r;
		d = b ^ crc[7:0];
		d = d ^ {d[3:0], 4'h0};
		r = {d, crc[15:8]};
		r = r ^ {12'h000, d[7:4]} ^ {5'h00, d, 3'b000};
		return r;
	endfunction

endpackage

### hw/rtl/fcrc_if.sv
// Interfaces: received byte channel and frame byte result channel.
interface fcrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcrc_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [7:0] byte_index;
	logic       last;
	logic       crc_ok;

	modport source (output valid, output frame_byte, output byte_index, output last,
		output crc_ok, input ready);
	modport sink   (input valid, input frame_byte, input byte_index, input last,
		input crc_ok, output ready);
endinterface

### hw/rtl/framed_crc16_receiver_unit.sv
// Top level: framed CRC-16 receiver, byte in, indexed frame byte out.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  rx      | in  | valid/ready  | rx_byte[7:0]
//  frame   | out | valid/ready  | frame_byte[7:0], byte_index[7:0], last, crc_ok
//
// One byte per cycle: the parser state and the byte-wide CRC update sit between
// the state registers and the single result register, so throughput is one
// request per clock while the sink keeps up.
// frame.valid rises in the cycle after rx accepts a byte that joins a frame.
// rx.ready drops only when the result register is full and frame.ready is low.
// Bytes that do not join a frame (hunt misses, bad second header) give no request.
// Reset (arst_n low) returns to header hunting with an empty result register.
module framed_crc16_receiver_unit (
	input  logic                clk,
	input  logic                arst_n,
	fcrc_byte_if.sink           rx,
	fcrc_frame_if.source        frame
);

	logic           fire;
	logic           in_ready;
	logic           res_vld;
	fcrc_pkg::res_t res;
	fcrc_pkg::res_t out_res;

	// byte accepted when the result register can take it
	assign rx.ready = in_ready;
	assign fire     = rx.valid && in_ready;

	fcrc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (rx.rx_byte),
		.res_vld (res_vld),
		.res     (res)
	);

	fcrc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_vld   (res_vld),
		.res       (res),
		.out_ready (frame.ready),
		.out_valid (frame.valid),
		.out_res   (out_res),
		.in_ready  (in_ready)
	);

	assign frame.frame_byte = out_res.frame_byte;
	assign frame.byte_index = out_res.byte_index;
	assign frame.last       = out_res.last;
	assign frame.crc_ok     = out_res.crc_ok;

endmodule

### hw/rtl/fcrc_parser.sv
// Frame parser: header hunt, length capture, running CRC and result build per byte.
module fcrc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          rx_byte,
	output logic                res_vld,
	output fcrc_pkg::res_t      res
);

	fcrc_pkg::phase_t phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  prev_q, prev_d;

	logic [7:0]  last_idx;
	logic        at_end;
	logic [15:0] crc_absorb;

	assign last_idx   = (len_q > fcrc_pkg::SHORT_LEN) ? (len_q - 8'd1) : fcrc_pkg::MIN_LAST_IDX;
	assign at_end     = (cnt_q >= last_idx);
	assign crc_absorb = fcrc_pkg::crc_step(crc_q, prev_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		prev_d  = prev_q;
		case (phase_q)
			fcrc_pkg::PH_HUNT: begin
				if (rx_byte == fcrc_pkg::HDR_FIRST) begin
					phase_d = fcrc_pkg::PH_REQ;
					cnt_d   = 8'd1;
					crc_d   = 16'h0000;
					prev_d  = rx_byte;
				end else begin
					len_d  = 8'd0;
					cnt_d  = 8'd0;
					crc_d  = 16'h0000;
					prev_d = 8'd0;
				end
			end
			fcrc_pkg::PH_REQ: begin
				if (rx_byte == fcrc_pkg::HDR_SECOND) begin
					phase_d = fcrc_pkg::PH_LEN;
					cnt_d   = 8'd2;
					crc_d   = crc_absorb;
					prev_d  = rx_byte;
				end else begin
					phase_d = fcrc_pkg::PH_HUNT;
					len_d   = 8'd0;
					cnt_d   = 8'd0;
					crc_d   = 16'h0000;
					prev_d  = 8'd0;
				end
			end
			fcrc_pkg::PH_LEN: begin
				phase_d = fcrc_pkg::PH_BODY;
				len_d   = rx_byte;
				cnt_d   = 8'd3;
				crc_d   = crc_absorb;
				prev_d  = rx_byte;
			end
			fcrc_pkg::PH_BODY: begin
				if (at_end) begin
					phase_d = fcrc_pkg::PH_HUNT;
					len_d   = 8'd0;
					cnt_d   = 8'd0;
					crc_d   = 16'h0000;
					prev_d  = 8'd0;
				end else begin
					cnt_d  = cnt_q + 8'd1;
					crc_d  = crc_absorb;
					prev_d = rx_byte;
				end
			end
			default: begin
				phase_d = fcrc_pkg::PH_HUNT;
			end
		endcase
	end

	// result for the byte being accepted
	always_comb begin
		res_vld        = 1'b1;
		res.frame_byte = rx_byte;
		res.byte_index = cnt_q;
		res.last       = 1'b0;
		res.crc_ok     = 1'b0;
		case (phase_q)
			fcrc_pkg::PH_HUNT: begin
				res_vld        = (rx_byte == fcrc_pkg::HDR_FIRST);
				res.byte_index = 8'd0;
			end
			fcrc_pkg::PH_REQ: begin
				res_vld = (rx_byte == fcrc_pkg::HDR_SECOND);
			end
			fcrc_pkg::PH_LEN: begin
				res_vld = 1'b1;
			end
			fcrc_pkg::PH_BODY: begin
				res.last   = at_end;
				res.crc_ok = at_end && ({rx_byte, prev_q} == crc_q);
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fcrc_pkg::PH_HUNT;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			crc_q   <= 16'h0000;
			prev_q  <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			prev_q  <= prev_d;
		end
	end

endmodule

### hw/rtl/fcrc_out_reg.sv
// Result register: holds one frame byte request until the sink takes it.
module fcrc_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           res_vld,
	input  fcrc_pkg::res_t res,
	input  logic           out_ready,
	output logic           out_valid,
	output fcrc_pkg::res_t out_res,
	output logic           in_ready
);

	logic           vld_q;
	fcrc_pkg::res_t res_q;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= fire && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_vld) begin
			res_q <= res;
		end
	end

endmodule

### hw/rtl/fcrc_checker.sv
// Port checker for the frame receiver, bound to the top level.
module fcrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic [7:0] byte_index,
	input logic       last,
	input logic       crc_ok
);

	// stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(byte_index)
		&& $stable(last) && $stable(crc_ok))
		else $error("stalled frame request changed");

	// no byte taken while a stalled result occupies the register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !rx_ready)
		else $error("rx accepted over a stalled result");

	// a request comes from a byte taken last cycle or is a held stalled one
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(rx_valid && rx_ready) || $past(out_valid && !out_ready))
		else $error("frame request without a taken byte");

	// index 0 is always the header byte
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_index == 8'd0) |-> (frame_byte == fcrc_pkg::HDR_FIRST))
		else $error("index 0 without header byte");

	// verdict only on the final byte, and a frame ends no earlier than index 3
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (crc_ok || last) |-> last && (byte_index >= fcrc_pkg::MIN_LAST_IDX))
		else $error("bad last or crc_ok mark");

endmodule

bind framed_crc16_receiver_unit fcrc_checker u_fcrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_valid   (rx.valid),
	.rx_ready   (rx.ready),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.frame_byte (frame.frame_byte),
	.byte_index (frame.byte_index),
	.last       (frame.last),
	.crc_ok     (frame.crc_ok)
);

### tb/tb_top.sv
// Testbench for the framed CRC-16 receiver: byte stream in, checked frame bytes out.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned MAX_WAIT     = 16;
	localparam int unsigned RANDOM_BYTES = 1700;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_REPORTS  = 10;
	// reflected form of the 0x1021 polynomial
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

	logic clk;
	logic arst_n;

	fcrc_byte_if  rx_ch ();
	fcrc_frame_if frame_ch ();

	framed_crc16_receiver_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.frame  (frame_ch)
	);

	// Expected frame bytes, oldest first, one per byte that joins a frame.
	fcrc_pkg::res_t expected_bytes[$];
	int unsigned    mismatch_count = 0;
	int unsigned    joined_count   = 0;
	int unsigned    cycle_count    = 0;

	// Idle patterns: each side flips between bursts (no waits) and random waits.
	bit src_burst  = 1'b0;
	bit sink_burst = 1'b0;
	int sink_hold  = 0;

	// Frame parser mirror.
	fcrc_pkg::phase_t frm_phase;
	logic [7:0]       frm_len;
	logic [7:0]       frm_count;
	logic [15:0]      frm_crc;
	logic [7:0]       frm_prev;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bitwise CRC-16/KERMIT update over one byte, LSB first.
	function automatic logic [15:0] kermit_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		return c;
	endfunction

	function automatic void frm_hunt();
		frm_phase = fcrc_pkg::PH_HUNT;
		frm_len   = 8'h00;
		frm_count = 8'h00;
		frm_crc   = 16'h0000;
		frm_prev  = 8'h00;
	endfunction

	// The newest byte is held back one step: the last two bytes of a frame
	// are the received CRC and must never enter the running CRC.
	function automatic void frm_absorb(input logic [7:0] b);
		frm_crc  = kermit_crc_byte(frm_crc, frm_prev);
		frm_prev = b;
	endfunction

	// Advance the parser by one received byte; returns 1 when the byte joins a frame.
	function automatic bit frm_parse_byte(input logic [7:0] b, output fcrc_pkg::res_t r);
		logic [7:0]  last_idx;
		logic [15:0] rx_crc;
		r            = '0;
		r.frame_byte = b;
		r.byte_index = frm_count;
		case (frm_phase)
			fcrc_pkg::PH_HUNT: begin
				if (b != fcrc_pkg::HDR_FIRST) begin
					frm_hunt();
					return 1'b0;
				end
				frm_crc      = 16'h0000;
				frm_prev     = b;
				r.byte_index = 8'd0;
				frm_count    = 8'd1;
				frm_phase    = fcrc_pkg::PH_REQ;
			end
			fcrc_pkg::PH_REQ: begin
				// a bad second header byte drops the frame, even when it is 0x3B
				if (b != fcrc_pkg::HDR_SECOND) begin
					frm_hunt();
					return 1'b0;
				end
				frm_absorb(b);
				frm_count = 8'd2;
				frm_phase = fcrc_pkg::PH_LEN;
			end
			fcrc_pkg::PH_LEN: begin
				frm_absorb(b);
				frm_len   = b;
				frm_count = 8'd3;
				frm_phase = fcrc_pkg::PH_BODY;
			end
			default: begin
				// short lengths still run the frame out to index 3
				last_idx = (frm_len > fcrc_pkg::SHORT_LEN) ? frm_len - 8'd1
					: fcrc_pkg::MIN_LAST_IDX;
				if (frm_count >= last_idx) begin
					rx_crc   = {b, frm_prev};
					r.last   = 1'b1;
					r.crc_ok = (rx_crc == frm_crc);
					frm_hunt();
				end else begin
					frm_absorb(b);
					frm_count = frm_count + 8'd1;
				end
			end
		endcase
		return 1'b1;
	endfunction

	// Send one byte: optional idle gap, then hold the request until it is taken.
	// Valid stays high afterwards, so back-to-back bytes keep the request line up without a gap.
	task automatic send_byte(input logic [7:0] b);
		int             gap;
		fcrc_pkg::res_t r;
		if ($urandom_range(0, 63) == 0)
			src_burst = ~src_burst;
		gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		if (frm_parse_byte(b, r)) begin
			expected_bytes = {expected_bytes, r};
			joined_count++;
		end
	endtask

	// Build and send one complete frame of length byte len.
	// good = 0 flips one bit past the length byte, so the CRC check fails
	// for every length above the short range.
	task automatic send_frame(input logic [7:0] len, input bit good);
		logic [7:0]  fb[$];
		int          last_idx;
		int          flip_idx;
		logic [15:0] crc;
		last_idx = (len > fcrc_pkg::SHORT_LEN) ? int'(len) - 1 : int'(fcrc_pkg::MIN_LAST_IDX);
		fb = {fb, fcrc_pkg::HDR_FIRST};
		fb = {fb, fcrc_pkg::HDR_SECOND};
		fb = {fb, len};
		while (fb.size() < last_idx - 1)
			fb = {fb, 8'($urandom_range(0, 255))};
		crc = 16'h0000;
		for (int i = 0; i < last_idx - 1; i++)
			crc = kermit_crc_byte(crc, fb[i]);
		// with a short length the length byte itself sits in the CRC low slot
		if (fb.size() == last_idx - 1)
			fb = {fb, crc[7:0]};
		fb = {fb, crc[15:8]};
		if (!good) begin
			flip_idx     = $urandom_range(3, last_idx);
			fb[flip_idx] = fb[flip_idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (fb[i])
			send_byte(fb[i]);
	endtask

	// Result sink: after each taken request, hold ready low for a drawn count.
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if ($urandom_range(0, 63) == 0)
				sink_burst = ~sink_burst;
			sink_hold = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
		end
		if (sink_hold > 0) begin
			frame_ch.ready <= 1'b0;
			sink_hold--;
		end else begin
			frame_ch.ready <= 1'b1;
		end
	end

	// Result checker: every taken request is matched against the oldest expectation.
	always @(posedge clk) begin
		fcrc_pkg::res_t got;
		fcrc_pkg::res_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			got.frame_byte = frame_ch.frame_byte;
			got.byte_index = frame_ch.byte_index;
			got.last       = frame_ch.last;
			got.crc_ok     = frame_ch.crc_ok;
			if (expected_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected frame byte %h idx %0d last %b ok %b", $realtime,
						got.frame_byte, got.byte_index, got.last, got.crc_ok);
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
							$realtime, want.frame_byte, want.byte_index, want.last,
							want.crc_ok, got.frame_byte, got.byte_index, got.last,
							got.crc_ok);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: errors");
		$finish;
	end

	// Bytes that never start a frame; none of them may give a request.
	task automatic test_hunt_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(fcrc_pkg::HDR_SECOND);
	endtask

	// Header then a wrong second byte: only the header shows up, at index 0.
	// A second 0x3B is dropped, not taken as a fresh header.
	task automatic test_bad_second_header();
		send_byte(fcrc_pkg::HDR_FIRST);
		send_byte(fcrc_pkg::HDR_FIRST);
		send_byte(fcrc_pkg::HDR_FIRST);
		send_byte(8'h00);
		send_byte(fcrc_pkg::HDR_FIRST);
		send_byte(8'hFF);
	endtask

	// Lengths 0 and 4, the ends of the 0..4 range, both end at index 3.
	task automatic test_short_frames();
		send_frame(8'd0, 1'b1);
		send_frame(fcrc_pkg::SHORT_LEN, 1'b1);
	endtask

	// Lengths just above the short range: a good CRC at length 5, then a corrupted one at length 6.
	task automatic test_min_body_frames();
		send_frame(8'd5, 1'b1);
		send_frame(8'd6, 1'b0);
	endtask

	// Mostly well-formed frames with random content; the rest is noise,
	// broken headers and bad CRCs. Runs until enough bytes joined frames.
	task automatic test_random_stream();
		int unsigned start_joined;
		int unsigned frame_no;
		int          pick;
		int          len_pick;
		logic [7:0]  len;
		start_joined = joined_count;
		frame_no     = 0;
		while (joined_count - start_joined < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				frame_no++;
				len_pick = $urandom_range(0, 99);
				if (frame_no % 40 == 17)
					len = 8'd255;
				else if (len_pick < 80)
					len = 8'($urandom_range(5, 24));
				else if (len_pick < 88)
					len = 8'($urandom_range(0, 4));
				else if (len_pick < 98)
					len = 8'($urandom_range(25, 80));
				else
					len = 8'($urandom_range(200, 255));
				send_frame(len, $urandom_range(0, 3) != 0);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6))
					send_byte(($urandom_range(0, 7) == 0) ? fcrc_pkg::HDR_SECOND
						: 8'($urandom_range(0, 255)));
			end else begin
				send_byte(fcrc_pkg::HDR_FIRST);
				send_byte(($urandom_range(0, 3) == 0) ? fcrc_pkg::HDR_FIRST
					: 8'($urandom_range(2, 255)));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		frm_hunt();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_hunt_noise();
		test_bad_second_header();
		test_short_frames();
		test_min_body_frames();
		test_random_stream();

		// last byte was taken at this edge; drop the request line
		rx_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		// the result is registered, so a short drain catches any stray request
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
